[rtl/core/dilated_conv1d_reflect_pad_core_defines.svh]
// Assertion macros shared by the core RTL.
// The assertions sample on clk and are disabled while arst_n is low.
`ifndef DILATED_CONV1D_REFLECT_PAD_CORE_DEFINES_SVH
`define DILATED_CONV1D_REFLECT_PAD_CORE_DEFINES_SVH

// Same-cycle implication.
`define DCRP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dcrp same-cycle check failed");

// Next-cycle implication.
`define DCRP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dcrp next-cycle check failed");

`endif

[rtl/core/dcrp_pkg.sv]
package dcrp_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_WEIGHT = 2'd0;
	localparam logic [1:0] KIND_BIAS   = 2'd1;
	localparam logic [1:0] KIND_ACT    = 2'd2;
	localparam logic [1:0] KIND_QUERY  = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DILATION    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELU_ON     = 3'd4;

	// Request item.
	typedef struct packed {
		logic [1:0]         kind;
		logic [6:0]         out_chan;
		logic [6:0]         in_chan;
		logic [2:0]         tap;
		logic [7:0]         time_step;
		logic signed [15:0] value;
	} req_t;

	// Response item.
	typedef struct packed {
		logic [6:0]         out_chan_res;
		logic [7:0]         time_step_res;
		logic signed [15:0] result;
		logic               range_error;
	} rsp_t;

	// Sequencer controls for the multiply-accumulate unit.
	typedef struct packed {
		logic load_bias;
		logic mul_valid;
	} mac_ctrl_t;

endpackage

[rtl/core/dcrp_mac.sv]
module dcrp_mac #(
	parameter int ACC_W = 44
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dcrp_pkg::mac_ctrl_t     ctrl,
	input  logic signed [15:0]      bias,
	input  logic signed [15:0]      w,
	input  logic signed [15:0]      a,
	input  logic                    relu_on,
	output logic                    busy,
	output logic signed [15:0]      result
);

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);
	localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(128);

	logic signed [31:0]      prod_s2;
	logic                    v_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-1:0] shr;

	// Product stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctrl.mul_valid;
		end
	end

	// One shared multiplier, registered before the accumulator.
	always_ff @(posedge clk) begin
		if (ctrl.mul_valid) begin
			prod_s2 <= w * a;
		end
	end

	// Accumulator starts from the bias aligned to Q16.16, sign extended.
	always_ff @(posedge clk) begin
		if (ctrl.load_bias) begin
			acc_q <= ACC_W'($signed({bias, 8'b0}));
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round to nearest by adding one half, floor shift to Q8.8, saturate, then ReLU if on.
	always_comb begin
		rnd = acc_q + HALF;
		shr = rnd >>> 8;
		if (shr > SAT_HI) begin
			result = 16'sh7fff;
		end else if (shr < SAT_LO) begin
			result = 16'sh8000;
		end else begin
			result = shr[15:0];
		end
		if (relu_on && result[15]) begin
			result = 16'sh0000;
		end
	end

	assign busy = v_s2;

endmodule

[rtl/core/dilated_conv1d_reflect_pad_core.sv]
// Write items leave the block idle; it is ready again on the next cycle.
// A query passes setup, run, drain and finish; run issues N = in_channels *
// kernel_size (after saturation) products, setup skips run when N is zero, and
// a bad output channel goes straight to finish. Queries run one at a time
// through the single multiply-accumulate unit, one product per cycle, and input
// stalls meanwhile. Reset clears sequencer and response valid, presets config.
`include "dilated_conv1d_reflect_pad_core_defines.svh"

module dilated_conv1d_reflect_pad_core #(
	parameter int MAX_IN_CHANNELS  = 128,
	parameter int MAX_OUT_CHANNELS = 128,
	parameter int MAX_TAPS         = 8,
	parameter int MAX_STEPS        = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  dcrp_pkg::req_t                     req,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output dcrp_pkg::rsp_t                     rsp,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dcrp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dcrp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int WDEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_TAPS;
	localparam int ADEPTH = MAX_IN_CHANNELS * MAX_STEPS;
	localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int AAW    = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
	localparam int BAW    = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
	localparam int CNW    = $clog2(MAX_IN_CHANNELS + 1);
	localparam int KNW    = $clog2(MAX_TAPS + 1);
	localparam int TW     = $clog2(MAX_STEPS + 1);
	localparam int IW     = ((TW > 9) ? TW : 9) + 3;
	localparam int ACC_W  = 32 + $clog2(MAX_IN_CHANNELS * MAX_TAPS + 1) + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	// Stores.
	logic [15:0] wmem [WDEPTH];
	logic [15:0] amem [ADEPTH];
	logic [15:0] bmem [MAX_OUT_CHANNELS];

	// Configuration registers.
	logic [7:0] in_ch_q;
	logic [3:0] ksize_q;
	logic [3:0] dil_q;
	logic [8:0] seq_len_q;
	logic       relu_q;

	// Sequencer state.
	logic [2:0]           state_q;
	logic [6:0]           oc_q;
	logic [7:0]           ts_q;
	logic                 bad_q;
	logic                 err_q;
	logic [CNW-1:0]       nci_q;
	logic [CNW-1:0]       ci_q;
	logic [KNW-1:0]       nk_q;
	logic [KNW-1:0]       kk_q;
	logic [TW-1:0]        t_q;
	logic signed [IW-1:0] pad_q;
	logic signed [IW-1:0] off_q;
	logic [WAW-1:0]       wrow_q;
	logic [AAW-1:0]       arow_q;
	logic                 issue_s1;
	logic [15:0]          w_rd_q;
	logic [15:0]          a_rd_q;
	logic [15:0]          b_rd_q;
	logic                 rsp_valid_q;
	dcrp_pkg::rsp_t       rsp_q;

	logic                 req_acc;
	logic                 query_acc;
	logic                 rsp_free;
	int                   nci_int;
	int                   nk_int;
	int                   t_int;
	int                   pad_int;
	logic signed [IW-1:0] idx_raw;
	logic signed [IW-1:0] refl;
	logic signed [IW-1:0] t_s;
	logic signed [IW-1:0] pos;
	logic                 clamp;
	logic [WAW-1:0]       w_raddr;
	logic [AAW-1:0]       a_raddr;
	logic [WAW-1:0]       w_waddr;
	logic [AAW-1:0]       a_waddr;
	logic                 w_wr_ok;
	logic                 a_wr_ok;
	logic                 oc_ok;
	logic                 last_tap;
	logic                 last_chan;
	dcrp_pkg::mac_ctrl_t  mac_ctrl;
	logic                 mac_busy;
	logic signed [15:0]   mac_result;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign query_acc = req_acc && req.kind == dcrp_pkg::KIND_QUERY;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q   <= 8'd1;
			ksize_q   <= 4'd1;
			dil_q     <= 4'd1;
			seq_len_q <= 9'd1;
			relu_q    <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dcrp_pkg::REG_IN_CHANNELS: in_ch_q   <= cfg_data[7:0];
				dcrp_pkg::REG_KERNEL_SIZE: ksize_q   <= cfg_data[3:0];
				dcrp_pkg::REG_DILATION:    dil_q     <= cfg_data[3:0];
				dcrp_pkg::REG_SEQ_LEN:     seq_len_q <= cfg_data[8:0];
				dcrp_pkg::REG_RELU_ON:     relu_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective loop bounds and padding from the current configuration.
	always_comb begin
		nci_int = (int'(in_ch_q) > MAX_IN_CHANNELS) ? MAX_IN_CHANNELS : int'(in_ch_q);
		nk_int  = (int'(ksize_q) > MAX_TAPS) ? MAX_TAPS : int'(ksize_q);
		if (seq_len_q == 9'd0) begin
			t_int = 1;
		end else if (int'(seq_len_q) > MAX_STEPS) begin
			t_int = MAX_STEPS;
		end else begin
			t_int = int'(seq_len_q);
		end
		pad_int = (nk_int == 0) ? 0 : ((int'(dil_q) * (nk_int - 1)) >> 1);
	end

	// Write addresses and range checks.
	always_comb begin
		w_wr_ok = (int'(req.out_chan) < MAX_OUT_CHANNELS) &&
			(int'(req.in_chan) < MAX_IN_CHANNELS) && (int'(req.tap) < MAX_TAPS);
		a_wr_ok = (int'(req.in_chan) < MAX_IN_CHANNELS) && (int'(req.time_step) < MAX_STEPS);
		oc_ok   = (int'(req.out_chan) < MAX_OUT_CHANNELS);
		w_waddr = WAW'((int'(req.out_chan) * MAX_IN_CHANNELS + int'(req.in_chan)) *
			MAX_TAPS + int'(req.tap));
		a_waddr = AAW'(int'(req.in_chan) * MAX_STEPS + int'(req.time_step));
	end

	// Tap index with one reflection, then clamping to the edges.
	always_comb begin
		t_s     = $signed(IW'(t_q));
		idx_raw = $signed(IW'(ts_q)) + off_q - pad_q;
		if (idx_raw < 0) begin
			refl = -idx_raw;
		end else if (idx_raw >= t_s) begin
			refl = (t_s <<< 1) - $signed(IW'(2)) - idx_raw;
		end else begin
			refl = idx_raw;
		end
		clamp = 1'b0;
		pos   = refl;
		if (refl < 0) begin
			pos   = '0;
			clamp = 1'b1;
		end else if (refl >= t_s) begin
			pos   = t_s - $signed(IW'(1));
			clamp = 1'b1;
		end
		w_raddr   = wrow_q + WAW'(kk_q);
		a_raddr   = arow_q + AAW'(pos);
		last_tap  = (kk_q == nk_q - KNW'(1));
		last_chan = (ci_q == nci_q - CNW'(1));
	end

	// Weight store.
	always_ff @(posedge clk) begin
		if (req_acc && req.kind == dcrp_pkg::KIND_WEIGHT && w_wr_ok) begin
			wmem[w_waddr] <= req.value;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			w_rd_q <= wmem[w_raddr];
		end
	end

	// Activation store.
	always_ff @(posedge clk) begin
		if (req_acc && req.kind == dcrp_pkg::KIND_ACT && a_wr_ok) begin
			amem[a_waddr] <= req.value;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			a_rd_q <= amem[a_raddr];
		end
	end

	// Bias store.
	always_ff @(posedge clk) begin
		if (req_acc && req.kind == dcrp_pkg::KIND_BIAS && oc_ok) begin
			bmem[BAW'(req.out_chan)] <= req.value;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && req.kind == dcrp_pkg::KIND_QUERY) begin
			b_rd_q <= bmem[BAW'(req.out_chan)];
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			issue_s1 <= (state_q == ST_RUN);
			// A taken response clears, unless the finishing query replaces it.
			if (rsp_valid_q && !rsp_stall && state_q != ST_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc && req.kind == dcrp_pkg::KIND_QUERY) begin
						state_q <= oc_ok ? ST_SETUP : ST_FIN;
					end
				end
				ST_SETUP: begin
					state_q <= (nci_q == '0 || nk_q == '0) ? ST_DRAIN : ST_RUN;
				end
				ST_RUN: begin
					if (last_tap && last_chan) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!issue_s1 && !mac_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Query context and loop counters.
	always_ff @(posedge clk) begin
		if (req_acc && req.kind == dcrp_pkg::KIND_QUERY) begin
			oc_q   <= req.out_chan;
			ts_q   <= req.time_step;
			bad_q  <= !oc_ok;
			err_q  <= !oc_ok || (int'(req.time_step) >= t_int);
			nci_q  <= CNW'(nci_int);
			nk_q   <= KNW'(nk_int);
			t_q    <= TW'(t_int);
			pad_q  <= IW'(pad_int);
			off_q  <= '0;
			ci_q   <= '0;
			kk_q   <= '0;
			wrow_q <= WAW'(int'(req.out_chan) * MAX_IN_CHANNELS * MAX_TAPS);
			arow_q <= '0;
		end else if (state_q == ST_RUN) begin
			if (clamp) begin
				err_q <= 1'b1;
			end
			if (last_tap) begin
				kk_q   <= '0;
				off_q  <= '0;
				ci_q   <= ci_q + CNW'(1);
				wrow_q <= wrow_q + WAW'(MAX_TAPS);
				arow_q <= arow_q + AAW'(MAX_STEPS);
			end else begin
				kk_q  <= kk_q + KNW'(1);
				off_q <= off_q + $signed(IW'(dil_q));
			end
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && rsp_free) begin
			rsp_q.out_chan_res  <= oc_q;
			rsp_q.time_step_res <= ts_q;
			rsp_q.result        <= bad_q ? 16'sh0000 : mac_result;
			rsp_q.range_error   <= err_q;
		end
	end

	assign mac_ctrl.load_bias = (state_q == ST_SETUP);
	assign mac_ctrl.mul_valid = issue_s1;

	dcrp_mac #(
		.ACC_W(ACC_W)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mac_ctrl),
		.bias    ($signed(b_rd_q)),
		.w       ($signed(w_rd_q)),
		.a       ($signed(a_rd_q)),
		.relu_on (relu_q),
		.busy    (mac_busy),
		.result  (mac_result)
	);

	`DCRP_ASSERT_IMPL(a_run_counters, state_q == ST_RUN, (kk_q < nk_q) && (ci_q < nci_q))
	`DCRP_ASSERT_IMPL(a_fin_drained, state_q == ST_FIN, !issue_s1 && !mac_busy)
	`DCRP_ASSERT_IMPL(a_rsp_from_fin, $rose(rsp_valid_q), $past(state_q) == ST_FIN)
	`DCRP_ASSERT_NEXT(a_query_starts, query_acc, state_q == ST_SETUP || state_q == ST_FIN)

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

	localparam int N_IN   = 128;
	localparam int N_OUT  = 128;
	localparam int N_TAPS = 8;
	localparam int N_STEP = 256;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	dcrp_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	dcrp_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [dcrp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [dcrp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	dilated_conv1d_reflect_pad_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copies of the block's stores and registers.
	logic signed [15:0] weight_mem [N_OUT*N_IN*N_TAPS];
	logic signed [15:0] bias_mem [N_OUT];
	logic signed [15:0] act_mem [N_IN*N_STEP];
	logic [7:0] cfg_in_ch = 8'd1;
	logic [3:0] cfg_taps = 4'd1;
	logic [3:0] cfg_dil = 4'd1;
	logic [8:0] cfg_len = 9'd1;
	logic cfg_relu = 1'b1;

	// Entries the stimulus has written so far; queries never read anything else.
	bit weight_set [N_OUT*N_IN*N_TAPS];
	bit bias_set [N_OUT];
	bit act_set [N_IN*N_STEP];

	dcrp_pkg::req_t req_backlog [$];
	dcrp_pkg::rsp_t conv_outputs_due [$];
	dcrp_pkg::rsp_t want;
	int n_errors = 0;
	int req_gap = 0;
	int rsp_hold = 0;
	bit req_burst = 1'b0;
	bit rsp_burst = 1'b0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Effective configuration after the block's saturation rules.
	function automatic int unsigned eff_channels();
		return (cfg_in_ch > N_IN) ? N_IN : cfg_in_ch;
	endfunction

	function automatic int unsigned eff_taps();
		return (cfg_taps > N_TAPS) ? N_TAPS : cfg_taps;
	endfunction

	function automatic longint eff_len();
		if (cfg_len == 0)
			return 1;
		return (cfg_len > N_STEP) ? N_STEP : cfg_len;
	endfunction

	function automatic longint pad_len();
		if (eff_taps() == 0)
			return 0;
		return (longint'(cfg_dil) * longint'(eff_taps() - 1)) / 2;
	endfunction

	function automatic int unsigned weight_addr(int unsigned oc, int unsigned ci, int unsigned tp);
		return (oc * N_IN + ci) * N_TAPS + tp;
	endfunction

	// Mirror a time index about the edges without repeating the edge sample, then clamp.
	function automatic int unsigned mirror_step(longint pos, longint span, output bit clamped);
		clamped = 1'b0;
		if (pos < 0)
			pos = -pos;
		else if (pos >= span)
			pos = 2 * span - 2 - pos;
		if (pos < 0) begin
			pos = 0;
			clamped = 1'b1;
		end else if (pos >= span) begin
			pos = span - 1;
			clamped = 1'b1;
		end
		return int'(pos);
	endfunction

	// Apply one accepted item to the shadow state; a query yields its expected output.
	task automatic absorb_item(dcrp_pkg::req_t r);
		dcrp_pkg::rsp_t ans;
		longint acc;
		longint span;
		int unsigned ix;
		bit clamped;
		bit err;
		case (r.kind)
			dcrp_pkg::KIND_WEIGHT: weight_mem[weight_addr(r.out_chan, r.in_chan, r.tap)] = r.value;
			dcrp_pkg::KIND_BIAS: bias_mem[r.out_chan] = r.value;
			dcrp_pkg::KIND_ACT: act_mem[r.in_chan * N_STEP + r.time_step] = r.value;
			default: begin
				span = eff_len();
				err = (r.time_step >= span);
				acc = longint'(bias_mem[r.out_chan]) * 256;
				for (int unsigned ci = 0; ci < eff_channels(); ci++) begin
					for (int unsigned kk = 0; kk < eff_taps(); kk++) begin
						ix = mirror_step(longint'(r.time_step) + longint'(kk) * cfg_dil
							- pad_len(), span, clamped);
						err |= clamped;
						acc += longint'(weight_mem[weight_addr(r.out_chan, ci, kk)])
							* longint'(act_mem[ci * N_STEP + ix]);
					end
				end
				acc = (acc + 128) >>> 8;
				if (acc > 32767)
					acc = 32767;
				if (acc < -32768)
					acc = -32768;
				if (cfg_relu && acc < 0)
					acc = 0;
				ans.out_chan_res = r.out_chan;
				ans.time_step_res = r.time_step;
				ans.result = acc[15:0];
				ans.range_error = err;
				conv_outputs_due.push_back(ans);
			end
		endcase
	endtask

	task automatic report_mismatch(string msg);
		n_errors++;
		$display("ERROR: %s", msg);
	endtask

	// Per-item wait, with occasional stretches of back-to-back traffic.
	function automatic int pick_wait(inout bit burst);
		if ($urandom_range(0, 23) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, 8);
	endfunction

	// Driver: presents queued items and feeds each accepted item to the shadow state.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				absorb_item(req);
			if (!req_valid || !req_stall) begin
				if (req_gap > 0) begin
					req_valid <= 1'b0;
					req_gap--;
				end else if (req_backlog.size() != 0) begin
					req <= req_backlog.pop_front();
					req_valid <= 1'b1;
					req_gap = pick_wait(req_burst);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted output with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (conv_outputs_due.size() == 0) begin
					report_mismatch($sformatf("unexpected output for channel %0d step %0d",
						rsp.out_chan_res, rsp.time_step_res));
				end else begin
					want = conv_outputs_due.pop_front();
					if (rsp.out_chan_res !== want.out_chan_res)
						report_mismatch($sformatf("out_chan_res got %0d want %0d",
							rsp.out_chan_res, want.out_chan_res));
					if (rsp.time_step_res !== want.time_step_res)
						report_mismatch($sformatf("time_step_res got %0d want %0d",
							rsp.time_step_res, want.time_step_res));
					if (rsp.result !== want.result)
						report_mismatch($sformatf("result for ch %0d step %0d got %0d want %0d",
							want.out_chan_res, want.time_step_res, rsp.result, want.result));
					if (rsp.range_error !== want.range_error)
						report_mismatch($sformatf("range_error for ch %0d step %0d got %b want %b",
							want.out_chan_res, want.time_step_res, rsp.range_error,
							want.range_error));
				end
				rsp_hold = pick_wait(rsp_burst);
			end
			if (rsp_hold > 0) begin
				rsp_stall <= 1'b1;
				rsp_hold--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Q8.8 data with a fair share of the extremes.
	function automatic logic [15:0] rand_q88();
		case ($urandom_range(0, 15))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_item(logic [1:0] k, logic [6:0] oc, logic [6:0] ic, logic [2:0] tp,
			logic [7:0] ts, logic [15:0] val);
		dcrp_pkg::req_t item;
		item = '{kind: k, out_chan: oc, in_chan: ic, tap: tp, time_step: ts, value: val};
		case (k)
			dcrp_pkg::KIND_WEIGHT: weight_set[weight_addr(oc, ic, tp)] = 1'b1;
			dcrp_pkg::KIND_BIAS: bias_set[oc] = 1'b1;
			dcrp_pkg::KIND_ACT: act_set[ic * N_STEP + ts] = 1'b1;
			default: ;
		endcase
		req_backlog.push_back(item);
	endtask

	// Write every entry a query will read that has not been written yet, then queue the query.
	task automatic push_query(logic [6:0] oc, logic [7:0] ts);
		int unsigned ix;
		bit clamped;
		if (!bias_set[oc])
			push_item(dcrp_pkg::KIND_BIAS, oc, 7'($urandom), 3'($urandom), 8'($urandom),
				rand_q88());
		for (int unsigned ci = 0; ci < eff_channels(); ci++) begin
			for (int unsigned kk = 0; kk < eff_taps(); kk++) begin
				if (!weight_set[weight_addr(oc, ci, kk)])
					push_item(dcrp_pkg::KIND_WEIGHT, oc, 7'(ci), 3'(kk), 8'($urandom),
						rand_q88());
				ix = mirror_step(longint'(ts) + longint'(kk) * cfg_dil - pad_len(),
					eff_len(), clamped);
				if (!act_set[ci * N_STEP + ix])
					push_item(dcrp_pkg::KIND_ACT, 7'($urandom), 7'(ci), 3'($urandom), 8'(ix),
						rand_q88());
			end
		end
		push_item(dcrp_pkg::KIND_QUERY, oc, 7'($urandom), 3'($urandom), ts, 16'($urandom));
	endtask

	task automatic cfg_write(logic [dcrp_pkg::CFG_IDX_W-1:0] idx,
			logic [dcrp_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			dcrp_pkg::REG_IN_CHANNELS: cfg_in_ch = data[7:0];
			dcrp_pkg::REG_KERNEL_SIZE: cfg_taps = data[3:0];
			dcrp_pkg::REG_DILATION: cfg_dil = data[3:0];
			dcrp_pkg::REG_SEQ_LEN: cfg_len = data[8:0];
			dcrp_pkg::REG_RELU_ON: cfg_relu = data[0];
			default: ;
		endcase
	endtask

	// Wait until every queued item is taken and every output has come back.
	task automatic settle(int cycles);
		while (req_backlog.size() != 0 || req_valid || conv_outputs_due.size() != 0)
			@(negedge clk);
		repeat (cycles)
			@(posedge clk);
	endtask

	// One setting of the registers followed by its items.
	task automatic run_phase(bit write_cfg, logic [8:0] ic_d, logic [8:0] ks_d,
			logic [8:0] dil_d, logic [8:0] len_d, logic [8:0] relu_d, int n_rand,
			bit directed);
		int unsigned span;
		int unsigned pick;
		int unsigned ci_top;
		int unsigned tap_top;
		settle(20);
		if (write_cfg) begin
			cfg_write(dcrp_pkg::REG_IN_CHANNELS, ic_d);
			cfg_write(dcrp_pkg::REG_KERNEL_SIZE, ks_d);
			cfg_write(dcrp_pkg::REG_DILATION, dil_d);
			cfg_write(dcrp_pkg::REG_SEQ_LEN, len_d);
			cfg_write(dcrp_pkg::REG_RELU_ON, relu_d);
		end
		@(negedge clk);
		span = eff_len();
		ci_top = (eff_channels() == 0) ? 0 : eff_channels() - 1;
		tap_top = (eff_taps() == 0) ? 0 : eff_taps() - 1;
		if (directed) begin
			// Both sequence edges, step 255 (past the end unless the sequence is full), and the lowest channel.
			push_query(7'd127, 8'd0);
			push_query(7'd127, 8'(span - 1));
			push_query(7'd127, 8'd255);
			push_query(7'd0, 8'(span / 2));
		end
		repeat (n_rand) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				push_query(($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 7)),
					($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, span - 1)));
			else if (pick == 5)
				push_item(dcrp_pkg::KIND_WEIGHT, 7'($urandom_range(0, 7)),
					7'($urandom_range(0, ci_top)), 3'($urandom_range(0, tap_top)), 8'($urandom),
					rand_q88());
			else if (pick == 6)
				push_item(dcrp_pkg::KIND_BIAS, 7'($urandom_range(0, 7)), 7'($urandom),
					3'($urandom), 8'($urandom), rand_q88());
			else if (pick == 7)
				push_item(dcrp_pkg::KIND_ACT, 7'($urandom), 7'($urandom_range(0, ci_top)),
					3'($urandom), 8'($urandom_range(0, span - 1)), rand_q88());
			else
				push_item(2'($urandom_range(0, 2)), 7'($urandom), 7'($urandom), 3'($urandom),
					8'($urandom), rand_q88());
		end
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Extreme values at the entries the first queries read.
		push_item(dcrp_pkg::KIND_BIAS, 7'd127, 7'd0, 3'd0, 8'd0, 16'h8000);
		push_item(dcrp_pkg::KIND_WEIGHT, 7'd127, 7'd0, 3'd0, 8'd255, 16'h7fff);
		push_item(dcrp_pkg::KIND_ACT, 7'd0, 7'd0, 3'd0, 8'd0, 16'h8000);

		// Reset setting, then the register extremes.
		run_phase(1'b0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 0, 1'b1);
		run_phase(1'b1, 9'd0, 9'd15, 9'd0, 9'd0, 9'd1, 0, 1'b1);
		run_phase(1'b1, 9'd3, 9'd0, 9'd15, 9'd511, 9'd0, 0, 1'b1);
		run_phase(1'b1, 9'd2, 9'd15, 9'd15, 9'd256, 9'd1, 0, 1'b1);

		// More channels than the block holds, one query over all of them.
		run_phase(1'b1, 9'h1c8, 9'd1, 9'd1, 9'd2, 9'd0, 0, 1'b0);
		push_query(7'd127, 8'd1);

		// Random settings, mostly few channels and short sequences.
		repeat (12) begin
			run_phase(1'b1, {1'($urandom), 8'($urandom_range(0, 4))},
				{5'($urandom), 4'($urandom_range(0, 15))},
				{5'($urandom), 4'($urandom_range(0, 15))},
				($urandom_range(0, 2) == 0) ? 9'($urandom) : 9'($urandom_range(1, 16)),
				{8'($urandom), 1'($urandom)}, 6, 1'b0);
		end

		settle(1100);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[dilated_conv1d_reflect_pad_core.f]
+incdir+rtl/core
rtl/core/dcrp_pkg.sv
rtl/core/dcrp_mac.sv
rtl/core/dilated_conv1d_reflect_pad_core.sv
verif/testbench.sv
